### sv/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Shared widths, constants and types for the smoothed Heaviside sine block.
// ----------------------------------------------------------------------------
`default_nettype none

package shs_pkg;

   // Input fixed-point format
   localparam int FRAC_BITS  = 16;
   localparam int DIST_WIDTH = 32;

   // Square root: radicand is band_width_squared << FRAC_BITS, padded to even
   localparam int RAD_W  = DIST_WIDTH + FRAC_BITS + ((DIST_WIDTH + FRAC_BITS) % 2);
   localparam int ROOT_W = RAD_W / 2;
   localparam int CMP_W  = (DIST_WIDTH > ROOT_W) ? DIST_WIDTH : ROOT_W;

   // Ratio |d|/w in Q1.16, rounded, up to 1.0
   localparam int OUT_FRAC = 16;
   localparam int OUT_W    = OUT_FRAC + 1;
   localparam int QUOT_W   = OUT_FRAC + 1;
   localparam int NUM_W    = ROOT_W + QUOT_W + 1;

   localparam logic [OUT_W-1:0] OUT_ONE  = OUT_W'(1) << OUT_FRAC;
   localparam logic [OUT_W-1:0] OUT_HALF = OUT_W'(1) << (OUT_FRAC - 1);

   // Sine series in Q2.30
   localparam logic [31:0] PI_Q30    = 32'd3373259426;
   localparam logic [28:0] INVPI_Q30 = 29'd341782638;
   localparam int          Q30_SHIFT = 30;
   localparam int          X_W       = 31;
   localparam int          X2_W      = 32;
   localparam int          TERM_W    = 33;
   localparam int          SUM_W     = 34;
   localparam int          SC_W      = 31;
   localparam int          SINE_W    = 16;
   localparam int          SERIES_TERMS = 6;
   localparam int          RECIP_SHIFT  = 33;
   localparam int          SINE_LAT     = 3 + 3 * SERIES_TERMS;

   // End-to-end latency: root steps, compare, quotient bits, sine, output
   localparam int LAT = ROOT_W + 1 + QUOT_W + SINE_LAT + 1;

   typedef logic signed [DIST_WIDTH-1:0] dist_type;
   typedef logic [DIST_WIDTH-1:0]        width_sq_type;
   typedef logic [OUT_W-1:0]             frac_type;
   typedef logic [ROOT_W-1:0]            root_type;
   typedef logic [SINE_W-1:0]            sine_type;

   // Per-item flags that ride along the pipeline
   typedef struct packed {
      logic neg;
      logic in_band;
      logic zero;
   } side_type;

endpackage

`default_nettype wire

### sv/shs_if.sv
// ----------------------------------------------------------------------------
// shs_req_if / shs_rsp_if
// Valid/ready channels for cells in and Heaviside values out.
// ----------------------------------------------------------------------------
`default_nettype none

interface shs_req_if import shs_pkg::*; ();
   logic         valid;
   logic         ready;
   dist_type     signed_distance;
   width_sq_type band_width_squared;

   modport source (output valid, output signed_distance, output band_width_squared,
                   input ready);
   modport sink   (input valid, input signed_distance, input band_width_squared,
                   output ready);
endinterface

interface shs_rsp_if import shs_pkg::*; ();
   logic     valid;
   logic     ready;
   frac_type heaviside_value;
   logic     inside_band;

   modport source (output valid, output heaviside_value, output inside_band,
                   input ready);
   modport sink   (input valid, input heaviside_value, input inside_band,
                   output ready);
endinterface

`default_nettype wire

### sv/shs_root.sv
// ----------------------------------------------------------------------------
// shs_root
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_root import shs_pkg::*; (
   input  wire logic         clock,
   input  wire logic         en,
   input  wire width_sq_type radicand,
   output root_type          root
);

   logic [ROOT_W+1:0] rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];

   for (genvar s = 0; s < ROOT_W; s++) begin : g_step
      logic [ROOT_W+1:0] rem_src;
      logic [ROOT_W-1:0] root_src;
      logic [RAD_W-1:0]  rad_src;
      logic [ROOT_W+3:0] rem_wide;
      logic [ROOT_W+3:0] trial;
      logic              take;

      if (s == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = RAD_W'({radicand, {FRAC_BITS{1'b0}}});
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign root_src = root_ff[s-1];
         assign rad_src  = rad_ff[s-1];
      end

      // Bring down the next bit pair and try (root << 2) | 1
      assign rem_wide = {rem_src, rad_src[RAD_W-1:RAD_W-2]};
      assign trial    = (ROOT_W+4)'({root_src, 2'b01});
      assign take     = (rem_wide >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= take ? (ROOT_W+2)'(rem_wide - trial) : (ROOT_W+2)'(rem_wide);
            root_ff[s] <= {root_src[ROOT_W-2:0], take};
            rad_ff[s]  <= rad_src << 2;
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

`default_nettype wire

### sv/shs_sine.sv
// ----------------------------------------------------------------------------
// shs_sine
// Pipelined 65536*sin(pi*q)/pi by a Taylor series in Q2.30.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_sine import shs_pkg::*; (
   input  wire logic     clock,
   input  wire logic     en,
   input  wire frac_type q,
   output sine_type      sine
);

   logic [X_W-1:0]           x_ff;
   logic [X2_W-1:0]          x2_ff   [SERIES_TERMS+1];
   logic [TERM_W-1:0]        term_ff [SERIES_TERMS+1];
   logic signed [SUM_W-1:0]  sum_ff  [SERIES_TERMS+1];
   sine_type                 sine_ff;

   logic [OUT_W-1:0] u;
   logic [47:0]      x_prod;
   logic [61:0]      xx_prod;

   // Fold onto the first quarter wave and scale by pi
   assign u      = (q <= OUT_HALF) ? q : OUT_W'(OUT_ONE - q);
   assign x_prod = 48'(PI_Q30) * 48'(u[OUT_FRAC-1:0]);

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= X_W'(x_prod >> OUT_FRAC);
      end
   end

   // Square the angle and seed the series
   assign xx_prod = 62'(x_ff) * 62'(x_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         x2_ff[0]   <= X2_W'(xx_prod >> Q30_SHIFT);
         term_ff[0] <= TERM_W'(x_ff);
         sum_ff[0]  <= SUM_W'(x_ff);
      end
   end

   for (genvar k = 1; k <= SERIES_TERMS; k++) begin : g_term
      localparam logic [63:0] DIVK  = 64'((2 * k) * (2 * k + 1));
      localparam logic [63:0] RECIP = (64'd1 << RECIP_SHIFT) / DIVK;

      logic [TERM_W-1:0]       raw1_ff;
      logic signed [SUM_W-1:0] sum1_ff;
      logic [X2_W-1:0]         x21_ff;
      logic [TERM_W-1:0]       raw2_ff;
      logic [TERM_W-1:0]       est2_ff;
      logic signed [SUM_W-1:0] sum2_ff;
      logic [X2_W-1:0]         x22_ff;

      logic [64:0]       mul_prod;
      logic [63:0]       rcp_prod;
      logic [TERM_W+7:0] back;
      logic [TERM_W-1:0] resid;
      logic [TERM_W-1:0] quot;

      // Multiply the previous term by x^2
      assign mul_prod = 65'(term_ff[k-1]) * 65'(x2_ff[k-1]);

      always_ff @(posedge clock) begin
         if (en) begin
            raw1_ff <= TERM_W'(mul_prod >> Q30_SHIFT);
            sum1_ff <= sum_ff[k-1];
            x21_ff  <= x2_ff[k-1];
         end
      end

      // Estimate the quotient by the reciprocal, low by at most one
      assign rcp_prod = 64'(raw1_ff) * 64'(RECIP[30:0]);

      always_ff @(posedge clock) begin
         if (en) begin
            raw2_ff <= raw1_ff;
            est2_ff <= TERM_W'(rcp_prod >> RECIP_SHIFT);
            sum2_ff <= sum1_ff;
            x22_ff  <= x21_ff;
         end
      end

      // Correct the estimate and accumulate with alternating sign
      assign back  = (TERM_W+8)'(est2_ff) * (TERM_W+8)'(DIVK[7:0]);
      assign resid = TERM_W'((TERM_W+8)'(raw2_ff) - back);
      assign quot  = (resid >= TERM_W'(DIVK[7:0])) ? TERM_W'(est2_ff + 1'b1) : est2_ff;

      always_ff @(posedge clock) begin
         if (en) begin
            term_ff[k] <= quot;
            x2_ff[k]   <= x22_ff;
            if (k % 2 == 1) begin
               sum_ff[k] <= sum2_ff - SUM_W'(quot);
            end else begin
               sum_ff[k] <= sum2_ff + SUM_W'(quot);
            end
         end
      end
   end

   // Clamp to 0..1.0, scale by 1/pi, round to Q0.16
   logic signed [SUM_W-1:0] sum_last;
   logic [SC_W-1:0]         sum_clamp;
   logic [59:0]             pi_prod;

   assign sum_last = sum_ff[SERIES_TERMS];

   always_comb begin
      if (sum_last < 0) begin
         sum_clamp = '0;
      end else if (sum_last > (SUM_W'(1) <<< Q30_SHIFT)) begin
         sum_clamp = SC_W'(1) << Q30_SHIFT;
      end else begin
         sum_clamp = SC_W'(sum_last);
      end
   end

   assign pi_prod = 60'(sum_clamp) * 60'(INVPI_Q30) + (60'd1 << 43);

   always_ff @(posedge clock) begin
      if (en) begin
         sine_ff <= SINE_W'(pi_prod >> 44);
      end
   end

   assign sine = sine_ff;

endmodule

`default_nettype wire

### sv/smoothed_heaviside_sine.sv
// Pipeline from input transfer to result: 24 root stages, one compare
// stage, 17 quotient stages, 21 sine stages and one output register.
// Throughput: one cell per cycle; a stalled result holds the whole pipeline.
// Reset: synchronous, active high; clears only the valid bits.
// ----------------------------------------------------------------------------
// smoothed_heaviside_sine
// Smoothed Heaviside of a level-set cell with a sine blend across the band.
// ----------------------------------------------------------------------------
`default_nettype none

module smoothed_heaviside_sine import shs_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   shs_req_if.sink   req,
   shs_rsp_if.source rsp
);

   logic           en;
   logic [LAT-1:0] vld_ff;

   // Advance whenever the output slot is free or being taken
   assign en        = !vld_ff[LAT-1] || rsp.ready;
   assign req.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req.valid};
      end
   end

   // Sign and magnitude at entry
   logic                  neg_in;
   logic [DIST_WIDTH-1:0] mag_in;

   assign neg_in = req.signed_distance[DIST_WIDTH-1];
   assign mag_in = neg_in ? DIST_WIDTH'(-req.signed_distance)
                          : DIST_WIDTH'(req.signed_distance);

   root_type root;

   shs_root u_root (
      .clock    (clock),
      .en       (en),
      .radicand (req.band_width_squared),
      .root     (root)
   );

   // Carry the magnitude and sign alongside the root
   logic [DIST_WIDTH-1:0] mag_d_ff [ROOT_W];
   logic                  neg_d_ff [ROOT_W];

   always_ff @(posedge clock) begin
      if (en) begin
         mag_d_ff[0] <= mag_in;
         neg_d_ff[0] <= neg_in;
         for (int i = 1; i < ROOT_W; i++) begin
            mag_d_ff[i] <= mag_d_ff[i-1];
            neg_d_ff[i] <= neg_d_ff[i-1];
         end
      end
   end

   // Band test and divider operands
   logic [DIST_WIDTH-1:0] mag_r;
   logic [NUM_W-1:0]      num_ff;
   logic [ROOT_W:0]       den_ff;
   side_type              side_ff;

   assign mag_r = mag_d_ff[ROOT_W-1];

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff          <= (NUM_W'(mag_r[ROOT_W-1:0]) << QUOT_W) + NUM_W'(root);
         den_ff          <= {root, 1'b0};
         side_ff.neg     <= neg_d_ff[ROOT_W-1];
         side_ff.in_band <= (CMP_W'(mag_r) < CMP_W'(root));
         side_ff.zero    <= (mag_r == '0);
      end
   end

   // Restoring division, one quotient bit per stage
   logic [NUM_W-1:0]  rem_ff  [QUOT_W];
   logic [QUOT_W-1:0] quot_ff [QUOT_W];
   logic [ROOT_W:0]   dvs_ff  [QUOT_W];
   side_type          dside_ff [QUOT_W];

   for (genvar s = 0; s < QUOT_W; s++) begin : g_div
      logic [NUM_W-1:0]  rem_src;
      logic [QUOT_W-1:0] quot_src;
      logic [ROOT_W:0]   den_src;
      side_type          side_src;
      logic [NUM_W-1:0]  den_sh;
      logic              take;

      if (s == 0) begin : g_first
         assign rem_src  = num_ff;
         assign quot_src = '0;
         assign den_src  = den_ff;
         assign side_src = side_ff;
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign quot_src = quot_ff[s-1];
         assign den_src  = dvs_ff[s-1];
         assign side_src = dside_ff[s-1];
      end

      assign den_sh = NUM_W'(den_src) << (QUOT_W - 1 - s);
      assign take   = (rem_src >= den_sh);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]   <= take ? NUM_W'(rem_src - den_sh) : rem_src;
            quot_ff[s]  <= {quot_src[QUOT_W-2:0], take};
            dvs_ff[s]   <= den_src;
            dside_ff[s] <= side_src;
         end
      end
   end

   // Clamp the ratio to 1.0
   frac_type q_div;

   assign q_div = (quot_ff[QUOT_W-1] > OUT_ONE) ? OUT_ONE : quot_ff[QUOT_W-1];

   sine_type sine;

   shs_sine u_sine (
      .clock (clock),
      .en    (en),
      .q     (q_div),
      .sine  (sine)
   );

   // Carry ratio and flags alongside the sine
   frac_type q_d_ff    [SINE_LAT];
   side_type sside_ff  [SINE_LAT];

   always_ff @(posedge clock) begin
      if (en) begin
         q_d_ff[0]   <= q_div;
         sside_ff[0] <= dside_ff[QUOT_W-1];
         for (int i = 1; i < SINE_LAT; i++) begin
            q_d_ff[i]   <= q_d_ff[i-1];
            sside_ff[i] <= sside_ff[i-1];
         end
      end
   end

   // Combine, halve with rounding and saturate; outside the band pick 0, one half or 1.0
   side_type                side_o;
   logic [OUT_W:0]          blend;
   logic signed [OUT_W+2:0] t_raw;
   logic signed [OUT_W+2:0] t_pos;
   logic [OUT_W+1:0]        t_half;
   frac_type                band_val;
   frac_type                hv_in;
   frac_type                hv_ff;
   logic                    in_band_ff;

   assign side_o = sside_ff[SINE_LAT-1];
   assign blend  = (OUT_W+1)'(q_d_ff[SINE_LAT-1]) + (OUT_W+1)'(sine);

   always_comb begin
      if (side_o.neg) begin
         t_raw = (OUT_W+3)'(OUT_ONE) - (OUT_W+3)'(blend);
      end else begin
         t_raw = (OUT_W+3)'(OUT_ONE) + (OUT_W+3)'(blend);
      end
      t_pos    = (t_raw < 0) ? '0 : t_raw;
      t_half   = (OUT_W+2)'((t_pos + 1) >>> 1);
      band_val = (t_half > (OUT_W+2)'(OUT_ONE)) ? OUT_ONE : OUT_W'(t_half);
      if (side_o.in_band) begin
         hv_in = band_val;
      end else if (side_o.zero) begin
         hv_in = OUT_HALF;
      end else if (side_o.neg) begin
         hv_in = '0;
      end else begin
         hv_in = OUT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hv_ff      <= hv_in;
         in_band_ff <= side_o.in_band;
      end
   end

   assign rsp.valid           = vld_ff[LAT-1];
   assign rsp.heaviside_value = hv_ff;
   assign rsp.inside_band     = in_band_ff;

endmodule

`default_nettype wire
